// File: design/uic_pkg.sv
// shared constants and types for the uncovered interval counter
package uic_pkg;
    localparam int MaxIntervals = 1024;
    localparam int CoordBits    = 16;
    localparam int AddrBits     = $clog2(MaxIntervals);
    localparam int FillBits     = $clog2(MaxIntervals + 1);
    localparam int CountBits    = 11;
    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    // sort key: start high, inverted end low, so ascending key order is
    // ascending start then descending end
    typedef logic [2*CoordBits-1:0] key_t;

    function automatic key_t make_key(logic [CoordBits-1:0] s, logic [CoordBits-1:0] e);
        return {s, ~e};
    endfunction

    function automatic logic [CoordBits-1:0] key_end(key_t k);
        return ~k[CoordBits-1:0];
    endfunction
endpackage

// File: design/uic_ram.sv
// simple dual port ram with registered read
module uic_ram #(
    parameter int Depth = 1024,
    parameter int Width = 32,
    parameter int Abits = $clog2(Depth)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [Abits-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic [Abits-1:0] raddr,
    output logic [Width-1:0] rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/uncovered_interval_counter.sv
// top level: load, merge sort over two ping-pong memories, sweep
// sequence: load the items; after the last of n items, ceil(log2 n) merge passes, each
//   merging run pairs, then a sweep over the sorted keys, then output
// throughput: one item per cycle while loading; one set at a time, sort time set by the
//   single shared key comparator and the memory read port, one key per merge cycle
// reset: synchronous active low; clears control and fill count, memories keep no reset
module uncovered_interval_counter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [uic_pkg::CoordBits-1:0] s_start_point,
    input  logic [uic_pkg::CoordBits-1:0] s_end_point,
    input  logic                          s_last_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [uic_pkg::CountBits-1:0] m_remaining_count,
    output logic                          m_overflow_flag
);
    localparam int AB = uic_pkg::AddrBits;
    localparam int FB = uic_pkg::FillBits;
    localparam int CB = uic_pkg::CountBits;
    localparam int KW = 2 * uic_pkg::CoordBits;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_PASS  = 7'b0000010,
        ST_RDA   = 7'b0000100,
        ST_RDB   = 7'b0001000,
        ST_MERGE = 7'b0010000,
        ST_SWEEP = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // two memories, data ping-pongs between them on each pass
    logic           we0, we1;
    logic [AB-1:0]  waddr;
    uic_pkg::key_t  wdata, rd0, rd1, rdq;
    logic [AB-1:0]  raddr;

    uic_ram #(.Depth(uic_pkg::MaxIntervals), .Width(KW)) u_ram0 (
        .aclk(aclk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
    );
    uic_ram #(.Depth(uic_pkg::MaxIntervals), .Width(KW)) u_ram1 (
        .aclk(aclk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
    );

    logic [FB-1:0] n_reg;       // loaded count
    logic          ovf_reg;
    logic          src_reg;     // memory holding current data
    logic [FB:0]   width_reg;   // run width of this pass
    logic [FB:0]   lo_reg;      // start of current run pair
    logic [FB:0]   a_reg, b_reg, mid_reg, hi_reg, k_reg;
    uic_pkg::key_t ka_reg, kb_reg;
    logic          fresh_a_reg, fresh_b_reg;   // run head arrives on the read port
    logic [uic_pkg::CoordBits-1:0] rmax_reg;
    logic [CB-1:0] tally_reg;
    logic [FB:0]   sidx_reg;    // sweep read index
    logic [1:0]    spipe_reg;   // sweep read valid pipe

    logic [FB:0]   n_w, mid_c, hi_c;
    uic_pkg::key_t ka_eff, kb_eff;
    logic          a_live, b_live, take_b;
    logic          n_full;

    assign rdq    = src_reg ? rd1 : rd0;
    assign n_w    = {1'b0, n_reg};
    assign n_full = (n_reg == FB'(uic_pkg::MaxIntervals));
    assign mid_c  = ((lo_reg + width_reg) > n_w) ? n_w : (lo_reg + width_reg);
    assign hi_c   = ((lo_reg + (width_reg << 1)) > n_w) ? n_w : (lo_reg + (width_reg << 1));
    assign a_live = (a_reg < mid_reg);
    assign b_live = (b_reg < hi_reg);
    assign ka_eff = fresh_a_reg ? rdq : ka_reg;
    assign kb_eff = fresh_b_reg ? rdq : kb_reg;
    // shared comparator: take from run b when run a is exhausted or b is strictly smaller
    assign take_b = b_live && (!a_live || (kb_eff < ka_eff));

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_OUT);
    assign m_remaining_count = tally_reg;
    assign m_overflow_flag   = ovf_reg;

    always_comb begin
        state_next = state_reg;
        we0 = 1'b0;
        we1 = 1'b0;
        waddr = n_reg[AB-1:0];
        wdata = uic_pkg::make_key(s_start_point, s_end_point);
        raddr = '0;
        unique case (state_reg)
            ST_LOAD: begin
                we0 = s_valid && !n_full;
                if (s_valid && s_last_item) begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS: begin
                if (width_reg >= n_w) begin
                    state_next = ST_SWEEP;
                end else begin
                    state_next = ST_RDA;
                end
            end
            ST_RDA: begin
                raddr = lo_reg[AB-1:0];
                state_next = ST_RDB;
            end
            ST_RDB: begin
                raddr = mid_c[AB-1:0];
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                waddr = k_reg[AB-1:0];
                wdata = take_b ? kb_eff : ka_eff;
                we0 = (a_live || b_live) && src_reg;
                we1 = (a_live || b_live) && !src_reg;
                raddr = take_b ? AB'(b_reg + 1'b1) : AB'(a_reg + 1'b1);
                if (!(a_live || b_live)) begin
                    state_next = (hi_reg >= n_w) ? ST_PASS : ST_RDA;
                end
            end
            ST_SWEEP: begin
                raddr = sidx_reg[AB-1:0];
                if (spipe_reg == 2'b00 && sidx_reg >= n_w) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            src_reg   <= 1'b0;
            width_reg <= (FB+1)'(1);
            tally_reg <= '0;
            rmax_reg  <= '0;
            spipe_reg <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_valid) begin
                        if (n_full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            n_reg <= n_reg + 1'b1;
                        end
                    end
                    src_reg   <= 1'b0;
                    width_reg <= (FB+1)'(1);
                    lo_reg    <= '0;
                    sidx_reg  <= '0;
                    spipe_reg <= '0;
                    rmax_reg  <= '0;
                    tally_reg <= '0;
                end
                ST_PASS: begin
                    lo_reg <= '0;
                end
                ST_RDA: begin
                    mid_reg <= mid_c;
                    hi_reg  <= hi_c;
                    a_reg   <= lo_reg;
                    b_reg   <= mid_c;
                    k_reg   <= lo_reg;
                end
                ST_RDB: begin
                    ka_reg <= rdq;  // data for address lo
                end
                ST_MERGE: begin
                    ka_reg <= ka_eff;
                    kb_reg <= kb_eff;
                    if (a_live || b_live) begin
                        k_reg <= k_reg + 1'b1;
                        if (take_b) begin
                            b_reg <= b_reg + 1'b1;
                        end else begin
                            a_reg <= a_reg + 1'b1;
                        end
                    end else begin
                        lo_reg <= hi_reg;
                        if (hi_reg >= n_w) begin
                            src_reg   <= !src_reg;
                            width_reg <= width_reg << 1;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (sidx_reg < n_w) begin
                        sidx_reg <= sidx_reg + 1'b1;
                    end
                    spipe_reg <= {spipe_reg[0], sidx_reg < n_w};
                    if (spipe_reg[0]) begin
                        if (uic_pkg::key_end(rdq) > rmax_reg) begin
                            rmax_reg <= uic_pkg::key_end(rdq);
                            if (tally_reg != uic_pkg::CountMax) begin
                                tally_reg <= tally_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        n_reg   <= '0;
                        ovf_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // run head refresh: a read issued in one cycle returns in the next, so the
    // run just consumed (or run b in its first merge cycle) takes its head
    // straight from the read port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_a_reg <= 1'b0;
            fresh_b_reg <= 1'b0;
        end else begin
            fresh_a_reg <= (state_reg == ST_MERGE) && (a_live || b_live) && !take_b;
            fresh_b_reg <= (state_reg == ST_RDB)
                           || ((state_reg == ST_MERGE) && (a_live || b_live) && take_b);
        end
    end
endmodule
